FILE: hw/rtl/ufe_pkg.sv
// Package: shared constants, beat types and sequencer states for the union-find engine.
`timescale 1ns / 1ps
`default_nettype none
package ufe_pkg;

	localparam int ELEMENT_COUNT = 1024;
	localparam int AW            = $clog2(ELEMENT_COUNT);
	localparam int SIZE_W        = $clog2(ELEMENT_COUNT + 1);
	localparam int FIELD_W       = 10;

	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_UNION = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] first_index;
		logic [FIELD_W-1:0] second_index;
	} req_t;

	typedef struct packed {
		logic               same_set;
		logic [FIELD_W-1:0] first_root;
		logic [FIELD_W-1:0] second_root;
	} rsp_t;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_P     = 6'b000100,
		S_GP    = 6'b001000,
		S_SA    = 6'b010000,
		S_SB    = 6'b100000
	} state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ufe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ufe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

FILE: hw/rtl/union_find_engine_unit.sv
// Top level: union-find engine (weighted quick-union, path halving) with its sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//  - Request channel: a beat is taken at a rising edge with start high and busy low.
//    req.cmd selects a connectivity query or a union of the two named elements.
//  - Result channel: done is high for exactly one cycle with rsp valid; the receiver
//    must take it then, there is no back-pressure.
//  - Every request gives exactly one result beat. busy stays high from the accepting
//    edge until the cycle done is shown; a new request may be taken in that cycle.
//  - Each root walk runs S_P then S_GP for every hop and ends in S_P at the root; a union
//    of two different sets adds S_SA and S_SB. Each hop costs two reads of the single
//    parent RAM read port (parent, then grandparent), and the halving write rides along
//    with the read of the next parent. With union by size a walk has at most log2 N hops.
//  - Reset: after arst_n releases the engine sweeps both RAMs, one entry per cycle,
//    writing parent[i] = i and size[i] = 1 for all ELEMENT_COUNT (1024) entries, busy high.
//  - Index bits above the element address are dropped (modulo a power-of-two count).
module union_find_engine_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire ufe_pkg::req_t req,
	output logic               done,
	output ufe_pkg::rsp_t      rsp
);

	// sequencer state and control
	ufe_pkg::state_t state_q;
	logic [ufe_pkg::AW-1:0] clr_q;
	logic done_q;

	// working registers of the current request
	logic cmd_q;
	logic second_q;             // walking the second element
	logic [ufe_pkg::AW-1:0] node_q;
	logic [ufe_pkg::AW-1:0] b_q;
	logic [ufe_pkg::AW-1:0] ra_q;
	logic [ufe_pkg::AW-1:0] rb_q;
	logic [ufe_pkg::SIZE_W-1:0] sa_q;
	ufe_pkg::rsp_t rsp_q;

	// RAM ports
	logic p_we;
	logic [ufe_pkg::AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
	logic s_we;
	logic [ufe_pkg::AW-1:0] s_waddr, s_raddr;
	logic [ufe_pkg::SIZE_W-1:0] s_wdata, s_rdata, size_sum;

	logic at_root;
	logic a_smaller;

	assign at_root   = (p_rdata == node_q);
	assign size_sum  = sa_q + s_rdata;
	assign a_smaller = (sa_q < s_rdata);

	ufe_ram #(
		.WIDTH(ufe_pkg::AW),
		.DEPTH(ufe_pkg::ELEMENT_COUNT)
	) u_parent_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	ufe_ram #(
		.WIDTH(ufe_pkg::SIZE_W),
		.DEPTH(ufe_pkg::ELEMENT_COUNT)
	) u_size_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	// RAM port steering
	always_comb begin
		p_we    = 1'b0;
		p_waddr = node_q;
		p_wdata = p_rdata;
		p_raddr = node_q;
		s_we    = 1'b0;
		s_waddr = ra_q;
		s_wdata = size_sum;
		s_raddr = ra_q;
		case (state_q)
			ufe_pkg::S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = ufe_pkg::SIZE_W'(1);
			end
			ufe_pkg::S_IDLE: begin
				p_raddr = ufe_pkg::AW'(req.first_index);
			end
			ufe_pkg::S_P: begin
				if (!at_root) begin
					p_raddr = p_rdata;          // fetch grandparent
				end else if (!second_q) begin
					p_raddr = b_q;              // start second walk
				end else begin
					s_raddr = ra_q;
				end
			end
			ufe_pkg::S_GP: begin
				// halve: node -> grandparent, and keep walking from there
				p_we    = 1'b1;
				p_waddr = node_q;
				p_wdata = p_rdata;
				p_raddr = p_rdata;
			end
			ufe_pkg::S_SA: begin
				s_raddr = rb_q;
			end
			ufe_pkg::S_SB: begin
				p_we = 1'b1;
				s_we = 1'b1;
				if (a_smaller) begin
					p_waddr = ra_q;
					p_wdata = rb_q;
					s_waddr = rb_q;
				end else begin
					p_waddr = rb_q;
					p_wdata = ra_q;
					s_waddr = ra_q;
				end
			end
			default: begin
				p_we = 1'b0;
				s_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufe_pkg::S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ufe_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ufe_pkg::AW'(ufe_pkg::ELEMENT_COUNT - 1)) begin
						state_q <= ufe_pkg::S_IDLE;
					end
				end
				ufe_pkg::S_IDLE: begin
					if (start) begin
						state_q <= ufe_pkg::S_P;
					end
				end
				ufe_pkg::S_P: begin
					if (!at_root) begin
						state_q <= ufe_pkg::S_GP;
					end else if (second_q) begin
						if (cmd_q == ufe_pkg::CMD_UNION && node_q != ra_q) begin
							state_q <= ufe_pkg::S_SA;
						end else begin
							state_q <= ufe_pkg::S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ufe_pkg::S_GP: begin
					state_q <= ufe_pkg::S_P;
				end
				ufe_pkg::S_SA: begin
					state_q <= ufe_pkg::S_SB;
				end
				ufe_pkg::S_SB: begin
					state_q <= ufe_pkg::S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ufe_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ufe_pkg::S_IDLE: begin
				if (start) begin
					cmd_q    <= req.cmd;
					node_q   <= ufe_pkg::AW'(req.first_index);
					b_q      <= ufe_pkg::AW'(req.second_index);
					second_q <= 1'b0;
				end
			end
			ufe_pkg::S_P: begin
				if (at_root) begin
					if (!second_q) begin
						ra_q     <= node_q;
						node_q   <= b_q;
						second_q <= 1'b1;
					end else begin
						rb_q                 <= node_q;
						rsp_q.same_set       <= (node_q == ra_q);
						rsp_q.first_root     <= ufe_pkg::FIELD_W'(ra_q);
						rsp_q.second_root    <= ufe_pkg::FIELD_W'(node_q);
					end
				end
			end
			ufe_pkg::S_GP: begin
				node_q <= p_rdata;
			end
			ufe_pkg::S_SA: begin
				sa_q <= s_rdata;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ufe_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// a result only follows work, never an idle cycle
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != ufe_pkg::S_IDLE)
		else $error("result strobe without a request in flight");

	// strobe is a single cycle per request
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// same_set must agree with the reported roots
	a_same_set: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.same_set == (rsp.first_root == rsp.second_root)))
		else $error("same_set disagrees with roots");

	// a halving step never sees a self-parent (would mean a missed root)
	a_no_self_halve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ufe_pkg::S_GP) |-> (p_rdata != node_q))
		else $error("halving step on a root");

	// a merge always ends in a result on the next edge
	a_merge_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ufe_pkg::S_SB) |=> done)
		else $error("merge finished without a result");
`endif

endmodule
`default_nettype wire

FILE: verif/union_find_engine_unit_test.sv
// Testbench: random and directed self-checking run of the union-find engine.
`timescale 1ns / 1ps
module union_find_engine_unit_test;
	import ufe_pkg::*;

	// Run shape.
	localparam int RANDOM_BEATS = 1630;
	localparam int CALM_FROM    = 700;   // sender never idles in [CALM_FROM, CALM_UNTIL)
	localparam int CALM_UNTIL   = 1000;
	localparam int IDLE_PERCENT = 17;
	localparam int DRAIN_CYCLES = 64;    // longer than the slowest request
	localparam int REPORT_LIMIT = 10;

	// One backlog entry: the request beat and whether the sender must wait for
	// every outstanding answer before offering it.
	typedef struct {
		req_t beat;
		bit   hold_for_drain;
	} request_slot_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	request_slot_t request_backlog[$];
	rsp_t          pending_answers[$];
	int            total_beats    = 0;
	int            accepted_beats = 0;
	int            fail_count     = 0;

	// Shadow copy of the forest: parent link and set size per element.
	logic [AW-1:0]     parent_link [ELEMENT_COUNT];
	logic [SIZE_W-1:0] set_size    [ELEMENT_COUNT];

	union_find_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Root walk with path halving: every visited node is re-pointed to its
	// grandparent, so the shadow forest tracks the RAM rewrites exactly.
	function automatic logic [AW-1:0] walk_to_root(input logic [AW-1:0] node);
		logic [AW-1:0] n;
		n = node;
		while (n != parent_link[n]) begin
			parent_link[n] = parent_link[parent_link[n]];
			n = parent_link[n];
		end
		return n;
	endfunction

	// Applies one request to the shadow forest and returns the answer it must give.
	function automatic rsp_t resolve_request(input req_t beat);
		logic [AW-1:0] ra;
		logic [AW-1:0] rb;
		rsp_t          ans;
		// first element walks first; its halving writes are seen by the second walk
		ra = walk_to_root(AW'(beat.first_index % ELEMENT_COUNT));
		rb = walk_to_root(AW'(beat.second_index % ELEMENT_COUNT));
		if (beat.cmd == CMD_UNION && ra != rb) begin
			// smaller tree goes under the larger; a tie hangs the second root
			if (set_size[ra] < set_size[rb]) begin
				parent_link[ra] = rb;
				set_size[rb]    = set_size[rb] + set_size[ra];
			end else begin
				parent_link[rb] = ra;
				set_size[ra]    = set_size[ra] + set_size[rb];
			end
		end
		ans.same_set    = (ra == rb);
		ans.first_root  = FIELD_W'(ra);
		ans.second_root = FIELD_W'(rb);
		return ans;
	endfunction

	task automatic queue_beat(input logic cmd, input int a, input int b, input bit drain);
		request_slot_t slot;
		slot.beat.cmd          = cmd;
		slot.beat.first_index  = FIELD_W'(a);
		slot.beat.second_index = FIELD_W'(b);
		slot.hold_for_drain    = drain;
		request_backlog.push_back(slot);
		total_beats++;
	endtask

	// Pick an element: mostly inside the current pocket so that sets grow deep
	// in places without the whole forest collapsing into one set.
	function automatic int pick_element(input int base, input int span);
		if ($urandom_range(99) < 70)
			return (base + $urandom_range(span - 1)) % ELEMENT_COUNT;
		return $urandom_range(ELEMENT_COUNT - 1);
	endfunction

	// Driver. The beat on the port is taken at an edge with start high and busy
	// low; at that edge the answer is predicted and the next beat chosen.
	// start/req get exactly one nonblocking update per edge.
	always @(posedge clk) begin
		logic          next_start;
		req_t          next_req;
		bit            send_now;
		bit            calm;
		request_slot_t slot;
		if (arst_n) begin
			next_start = start;
			next_req   = req;
			if (start && !busy) begin
				pending_answers.push_back(resolve_request(req));
				accepted_beats++;
				next_start = 1'b0;
			end
			if (!next_start && request_backlog.size() != 0) begin
				calm     = accepted_beats >= CALM_FROM && accepted_beats < CALM_UNTIL;
				send_now = 1'b1;
				// drain marker: hold off until every answer is back
				if (request_backlog[0].hold_for_drain && pending_answers.size() != 0)
					send_now = 1'b0;
				else if (!calm && $urandom_range(99) < IDLE_PERCENT)
					send_now = 1'b0;
				if (send_now) begin
					slot       = request_backlog.pop_front();
					next_start = 1'b1;
					next_req   = slot.beat;
				end
			end
			start <= next_start;
			req   <= next_req;
		end
	end

	// Monitor. done marks a single-cycle result beat; it is checked against
	// the oldest prediction, field by field.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected result beat: same=%0d roots=%0d/%0d",
						rsp.same_set, rsp.first_root, rsp.second_root);
			end else begin
				want = pending_answers.pop_front();
				if (rsp.same_set !== want.same_set || rsp.first_root !== want.first_root ||
					rsp.second_root !== want.second_root) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch: exp same=%0d roots=%0d/%0d, got same=%0d roots=%0d/%0d",
							want.same_set, want.first_root, want.second_root,
							rsp.same_set, rsp.first_root, rsp.second_root);
				end
			end
		end
	end

	// Hard stop well beyond the slowest legal run (clear sweep included).
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int base;
		int span;
		int a;
		int b;
		for (int k = 0; k < ELEMENT_COUNT; k++) begin
			parent_link[k] = AW'(k);
			set_size[k]    = SIZE_W'(1);
		end

		// Directed: extremes, both commands, repeat elements, ties, deep trees.
		queue_beat(CMD_QUERY, 0, 0, 1'b0);        // same element, query
		queue_beat(CMD_UNION, 0, 1023, 1'b0);     // extreme indices
		queue_beat(CMD_QUERY, 1023, 0, 1'b0);     // now connected
		queue_beat(CMD_UNION, 1023, 0, 1'b0);     // union within one set
		queue_beat(CMD_UNION, 7, 7, 1'b0);        // union of an element with itself
		queue_beat(CMD_QUERY, 1023, 1023, 1'b0);
		queue_beat(CMD_UNION, 2, 3, 1'b0);
		queue_beat(CMD_UNION, 4, 5, 1'b0);
		queue_beat(CMD_UNION, 2, 4, 1'b0);        // equal sizes: second root under first
		queue_beat(CMD_UNION, 6, 5, 1'b0);        // singleton goes under the bigger set
		queue_beat(CMD_UNION, 10, 11, 1'b0);
		queue_beat(CMD_UNION, 12, 13, 1'b0);
		queue_beat(CMD_UNION, 10, 12, 1'b0);
		queue_beat(CMD_UNION, 14, 15, 1'b0);
		queue_beat(CMD_UNION, 16, 17, 1'b0);
		queue_beat(CMD_UNION, 14, 16, 1'b0);
		queue_beat(CMD_UNION, 10, 14, 1'b0);      // depth-3 tree
		queue_beat(CMD_QUERY, 11, 17, 1'b0);      // long walks, halving rewrites
		queue_beat(CMD_QUERY, 17, 11, 1'b0);
		queue_beat(CMD_UNION, 1023, 2, 1'b1);     // smaller first set, after a drain
		queue_beat(CMD_QUERY, 682, 341, 1'b0);    // alternating index bits
		queue_beat(CMD_UNION, 682, 341, 1'b0);

		// Random: pockets of varying width move around the element space.
		base = 0;
		span = 2;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 64 == 0) begin
				base = $urandom_range(ELEMENT_COUNT - 1);
				span = 1 << $urandom_range(1, 6);
			end
			a = pick_element(base, span);
			b = ($urandom_range(99) < 5) ? a : pick_element(base, span);
			queue_beat(($urandom_range(99) < 45) ? CMD_UNION : CMD_QUERY, a, b,
				n % 400 == 200);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_beats != total_beats || pending_answers.size() != 0)
			@(posedge clk);
		// any stray beat after the last answer is caught by the monitor
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_answers.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
